[sv/apd_pkg.sv]
package apd_pkg;

    localparam int MAX_WIDTH    = 1024;
    localparam int MAX_CHANNELS = 4;
    localparam int NUM_LANES    = 4;

    localparam int BYTE_W  = 8;
    localparam int WORD_W  = NUM_LANES * BYTE_W;
    localparam int COL_W   = $clog2(MAX_WIDTH);
    localparam int EW_W    = COL_W + 1;
    localparam int WIDTH_W = 11;
    localparam int CHAN_W  = 3;
    localparam int IDX_W   = 2;
    localparam int DATA_W  = 11;

    localparam logic [IDX_W-1:0]   REG_IMAGE_WIDTH   = IDX_W'(0);
    localparam logic [IDX_W-1:0]   REG_CHANNEL_COUNT = IDX_W'(1);
    localparam logic [WIDTH_W-1:0] WIDTH_RESET       = WIDTH_W'(1024);
    localparam logic [CHAN_W-1:0]  CHAN_RESET        = CHAN_W'(3);

    typedef enum logic [1:0] {
        PRED_NONE,
        PRED_LEFT,
        PRED_ABOVE,
        PRED_AVG
    } t_pred;

    typedef logic [BYTE_W-1:0] t_byte;

endpackage

[sv/apd_if.sv]
interface apd_in_if;
    import apd_pkg::*;
    logic  valid;
    logic  ready;
    t_byte residual_c0;
    t_byte residual_c1;
    t_byte residual_c2;
    t_byte residual_c3;
    logic  stripe_start;

    modport source (
        output valid, residual_c0, residual_c1, residual_c2, residual_c3, stripe_start,
        input  ready
    );
    modport sink (
        input  valid, residual_c0, residual_c1, residual_c2, residual_c3, stripe_start,
        output ready
    );
endinterface

interface apd_out_if;
    import apd_pkg::*;
    logic  valid;
    logic  ready;
    t_byte pixel_c0;
    t_byte pixel_c1;
    t_byte pixel_c2;
    t_byte pixel_c3;
    logic  row_end;

    modport source (
        output valid, pixel_c0, pixel_c1, pixel_c2, pixel_c3, row_end,
        input  ready
    );
    modport sink (
        input  valid, pixel_c0, pixel_c1, pixel_c2, pixel_c3, row_end,
        output ready
    );
endinterface

interface apd_cfg_if;
    import apd_pkg::*;
    logic              valid;
    logic              ready;
    logic [IDX_W-1:0]  index;
    logic [DATA_W-1:0] data;

    modport source (
        output valid, index, data,
        input  ready
    );
    modport sink (
        input  valid, index, data,
        output ready
    );
endinterface

[sv/apd_ram.sv]
module apd_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule

[sv/apd_lane.sv]
module apd_lane (
    input  apd_pkg::t_byte i_residual,
    input  apd_pkg::t_byte i_above,
    input  apd_pkg::t_byte i_left,
    input  apd_pkg::t_pred i_mode,
    input  logic           i_active,
    output apd_pkg::t_byte o_pixel
);
    import apd_pkg::*;

    logic [BYTE_W:0] sum;
    t_byte           pred;
    t_byte           value;

    assign sum = {1'b0, i_above} + {1'b0, i_left};

    always_comb begin
        case (i_mode)
            PRED_NONE:  pred = '0;
            PRED_LEFT:  pred = i_left;
            PRED_ABOVE: pred = i_above;
            PRED_AVG:   pred = sum[BYTE_W:1];
            default:    pred = '0;
        endcase
    end

    assign value   = i_residual + pred;
    assign o_pixel = i_active ? value : '0;
endmodule

[sv/apd_merge.sv]
module apd_merge (
    input  apd_pkg::t_byte              i_lane [apd_pkg::NUM_LANES],
    input  logic [apd_pkg::CHAN_W-1:0]  i_chans,
    output logic [apd_pkg::WORD_W-1:0]  o_word,
    output apd_pkg::t_byte              o_pixel [apd_pkg::NUM_LANES]
);
    import apd_pkg::*;

    logic swap;

    assign swap = (i_chans >= CHAN_W'(3));

    always_comb begin
        for (int c = 0; c < NUM_LANES; c++) begin
            o_word[c*BYTE_W +: BYTE_W] = i_lane[c];
            o_pixel[c]                 = i_lane[c];
        end
        if (swap) begin
            o_pixel[0] = i_lane[2];
            o_pixel[2] = i_lane[0];
        end
    end
endmodule

[sv/average_predictor_pixel_decode.sv]
// Channel  Dir   Transaction contents
// i_in     in    residual_c0..c3, stripe_start
// o_out    out   pixel_c0..c3 (0/2 swapped for 3-4 channels), row_end
// i_cfg    in    index (0 image_width, 1 channel_count), data
//
// One pixel per cycle sustained while the output is not stalled. The accepting edge registers
// the input and issues the line-buffer read; the lane stage runs four channel lanes and
// registers the result in the output register; the left-pixel loop closes within that stage.
// Reset starts a stripe; the line buffer is not cleared.
// A stalled output holds the lane stage; input ready drops only while both are full.
module average_predictor_pixel_decode (
    input  logic i_clk,
    input  logic i_rst_n,
    apd_in_if.sink    i_in,
    apd_out_if.source o_out,
    apd_cfg_if.sink   i_cfg
);
    import apd_pkg::*;

    logic [WIDTH_W-1:0] r_width;
    logic [CHAN_W-1:0]  r_chans;
    logic [EW_W-1:0]    eff_w;
    logic [CHAN_W-1:0]  eff_chans;

    logic [COL_W-1:0]   r_col;
    logic               r_first_row;
    logic [WORD_W-1:0]  r_left;

    logic               r_s1_valid;
    t_byte              r_s1_res [NUM_LANES];
    t_pred              r_s1_mode;
    logic               r_s1_row_end;
    logic [COL_W-1:0]   r_s1_addr;
    logic               r_byp;
    logic [WORD_W-1:0]  r_byp_data;

    logic               r_out_valid;
    t_byte              r_out_px [NUM_LANES];
    logic               r_out_row_end;

    logic               in_acc;
    logic               s1_adv;
    logic [COL_W-1:0]   col0;
    logic               fr0;
    t_pred              mode0;
    logic               acc_row_end;
    logic [WORD_W-1:0]  ram_rdata;
    logic [WORD_W-1:0]  above;
    t_byte              lane_px [NUM_LANES];
    t_byte              merged_px [NUM_LANES];
    logic [WORD_W-1:0]  rebuilt;
    t_byte              in_res [NUM_LANES];

    always_comb begin
        if (r_width == '0) begin
            eff_w = EW_W'(1);
        end else if (32'(r_width) > MAX_WIDTH) begin
            eff_w = EW_W'(MAX_WIDTH);
        end else begin
            eff_w = EW_W'(r_width);
        end
        if (r_chans == '0) begin
            eff_chans = CHAN_W'(1);
        end else if (32'(r_chans) > MAX_CHANNELS) begin
            eff_chans = CHAN_W'(MAX_CHANNELS);
        end else begin
            eff_chans = r_chans;
        end
    end

    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width <= WIDTH_RESET;
            r_chans <= CHAN_RESET;
        end else if (i_cfg.valid) begin
            case (i_cfg.index)
                REG_IMAGE_WIDTH:   r_width <= i_cfg.data[WIDTH_W-1:0];
                REG_CHANNEL_COUNT: r_chans <= i_cfg.data[CHAN_W-1:0];
                default: ;
            endcase
        end
    end

    assign s1_adv     = r_s1_valid && (!r_out_valid || o_out.ready);
    assign i_in.ready = !r_s1_valid || s1_adv;
    assign in_acc     = i_in.valid && i_in.ready;

    assign col0 = i_in.stripe_start ? '0 : r_col;
    assign fr0  = i_in.stripe_start || r_first_row;
    assign acc_row_end = ((EW_W'(col0) + EW_W'(1)) >= eff_w);

    always_comb begin
        if (fr0 && col0 == '0) begin
            mode0 = PRED_NONE;
        end else if (fr0) begin
            mode0 = PRED_LEFT;
        end else if (col0 == '0) begin
            mode0 = PRED_ABOVE;
        end else begin
            mode0 = PRED_AVG;
        end
    end

    assign in_res[0] = i_in.residual_c0;
    assign in_res[1] = i_in.residual_c1;
    assign in_res[2] = i_in.residual_c2;
    assign in_res[3] = i_in.residual_c3;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col       <= '0;
            r_first_row <= 1'b1;
            r_s1_valid  <= 1'b0;
            r_byp       <= 1'b0;
        end else begin
            if (in_acc) begin
                r_s1_valid <= 1'b1;
                r_byp      <= s1_adv && (r_s1_addr == col0);
                if (acc_row_end) begin
                    r_col       <= '0;
                    r_first_row <= 1'b0;
                end else begin
                    r_col       <= col0 + COL_W'(1);
                    r_first_row <= fr0;
                end
            end else if (s1_adv) begin
                r_s1_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_s1_res     <= in_res;
            r_s1_mode    <= mode0;
            r_s1_row_end <= acc_row_end;
            r_s1_addr    <= col0;
            r_byp_data   <= rebuilt;
        end
    end

    apd_ram #(
        .WIDTH (WORD_W),
        .DEPTH (MAX_WIDTH)
    ) u_line_buf (
        .i_clk   (i_clk),
        .i_we    (s1_adv),
        .i_waddr (r_s1_addr),
        .i_wdata (rebuilt),
        .i_re    (in_acc),
        .i_raddr (col0),
        .o_rdata (ram_rdata)
    );

    assign above = r_byp ? r_byp_data : ram_rdata;

    for (genvar c = 0; c < NUM_LANES; c++) begin : g_lane
        apd_lane u_lane (
            .i_residual (r_s1_res[c]),
            .i_above    (above[c*BYTE_W +: BYTE_W]),
            .i_left     (r_left[c*BYTE_W +: BYTE_W]),
            .i_mode     (r_s1_mode),
            .i_active   (CHAN_W'(c) < eff_chans),
            .o_pixel    (lane_px[c])
        );
    end

    apd_merge u_merge (
        .i_lane  (lane_px),
        .i_chans (eff_chans),
        .o_word  (rebuilt),
        .o_pixel (merged_px)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_left      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (s1_adv) begin
                r_left      <= rebuilt;
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_adv) begin
            r_out_px      <= merged_px;
            r_out_row_end <= r_s1_row_end;
        end
    end

    assign o_out.valid    = r_out_valid;
    assign o_out.pixel_c0 = r_out_px[0];
    assign o_out.pixel_c1 = r_out_px[1];
    assign o_out.pixel_c2 = r_out_px[2];
    assign o_out.pixel_c3 = r_out_px[3];
    assign o_out.row_end  = r_out_row_end;

    a_stage_advance: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s1_adv |=> r_out_valid)
        else $error("result lost between stage and output register");

    a_no_overrun: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc |-> (!r_s1_valid || s1_adv))
        else $error("accepted over an unmoved stage");

    a_row_wrap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc && acc_row_end |=> (r_col == '0) && !r_first_row)
        else $error("column did not wrap at row end");

    a_bypass: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc && s1_adv && (r_s1_addr == col0) |=> r_byp)
        else $error("same-address line buffer hazard not bypassed");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s1_valid && !s1_adv |=> r_s1_valid && $stable(r_s1_addr))
        else $error("stalled stage changed");
endmodule

[verif/tb_average_predictor_pixel_decode.sv]
module tb_average_predictor_pixel_decode;
    timeunit 1ns;
    timeprecision 1ps;

    import apd_pkg::*;

    typedef struct packed {
        logic                             stripe_start;
        logic [NUM_LANES-1:0][BYTE_W-1:0] res;
    } t_residual;

    typedef struct packed {
        logic                             row_end;
        logic [NUM_LANES-1:0][BYTE_W-1:0] pix;
    } t_pixel;

    logic i_clk = 1'b0;
    logic i_rst_n;

    apd_in_if  in_if();
    apd_out_if out_if();
    apd_cfg_if cfg_if();

    average_predictor_pixel_decode u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if),
        .o_out   (out_if),
        .i_cfg   (cfg_if)
    );

    always #5ns i_clk = ~i_clk;

    // decoder state mirror
    logic [WORD_W-1:0]  row_store [MAX_WIDTH];
    bit                 row_store_valid [MAX_WIDTH];
    logic [WORD_W-1:0]  left_word;
    int                 col_pos;
    bit                 first_row;
    logic [WIDTH_W-1:0] cfg_width;
    logic [CHAN_W-1:0]  cfg_chans;

    t_residual pixel_queue [$];
    t_pixel    pixel_expect_q [$];

    int   error_count = 0;
    int   result_no = 0;
    bit   src_idle_on = 1'b1;
    bit   snk_idle_on = 1'b1;
    int   src_gap = 0;
    int   snk_gap = 0;
    int   hold_len = 0;
    int   hold_left = 0;
    logic hold_go = 1'b0;
    logic hold_seen = 1'b0;

    t_residual cur_item;
    t_pixel    got_px;
    t_pixel    want_px;

    task automatic report_mismatch(string msg);
        if (error_count < 100)
            $display("[%0t] mismatch: %s", $realtime, msg);
        error_count++;
    endtask

    function automatic int idle_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 90) return $urandom_range(1, 3);
        if (r < 98) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic int eff_width();
        if (cfg_width == 0) return 1;
        if (cfg_width > MAX_WIDTH) return MAX_WIDTH;
        return int'(cfg_width);
    endfunction

    function automatic int eff_chans();
        if (cfg_chans == 0) return 1;
        if (cfg_chans > MAX_CHANNELS) return MAX_CHANNELS;
        return int'(cfg_chans);
    endfunction

    function automatic t_pixel rebuild_pixel(t_residual it);
        int                width;
        int                chans;
        t_pred             mode;
        logic [WORD_W-1:0] above;
        logic [WORD_W-1:0] word;
        logic [BYTE_W:0]   sum;
        t_byte             pred;
        t_byte             lane [NUM_LANES];
        t_byte             tmp;
        t_pixel            px;
        width = eff_width();
        chans = eff_chans();
        if (it.stripe_start) begin
            col_pos = 0;
            first_row = 1'b1;
        end
        above = row_store[col_pos];
        if (first_row && col_pos == 0) mode = PRED_NONE;
        else if (first_row) mode = PRED_LEFT;
        else if (col_pos == 0) mode = PRED_ABOVE;
        else mode = PRED_AVG;
        word = '0;
        for (int c = 0; c < NUM_LANES; c++) begin
            if (c >= chans) begin
                lane[c] = '0;
            end else begin
                case (mode)
                    PRED_NONE:  pred = '0;
                    PRED_LEFT:  pred = left_word[BYTE_W*c +: BYTE_W];
                    PRED_ABOVE: pred = above[BYTE_W*c +: BYTE_W];
                    default: begin
                        sum = {1'b0, above[BYTE_W*c +: BYTE_W]}
                            + {1'b0, left_word[BYTE_W*c +: BYTE_W]};
                        pred = sum[BYTE_W:1];
                    end
                endcase
                lane[c] = it.res[c] + pred;
                word[BYTE_W*c +: BYTE_W] = lane[c];
            end
        end
        left_word = word;
        row_store[col_pos] = word;
        row_store_valid[col_pos] = 1'b1;
        px.row_end = (col_pos + 1 >= width);
        if (px.row_end) begin
            col_pos = 0;
            first_row = 1'b0;
        end else begin
            col_pos++;
        end
        if (chans >= 3) begin
            tmp = lane[0];
            lane[0] = lane[2];
            lane[2] = tmp;
        end
        for (int c = 0; c < NUM_LANES; c++)
            px.pix[c] = lane[c];
        return px;
    endfunction

    function automatic t_residual make_residual(t_byte b0, t_byte b1, t_byte b2, t_byte b3,
                                                logic start);
        t_residual it;
        it.res = {b3, b2, b1, b0};
        it.stripe_start = start;
        return it;
    endfunction

    function automatic t_residual random_residual(logic start);
        return make_residual(t_byte'($urandom_range(0, 255)), t_byte'($urandom_range(0, 255)),
                             t_byte'($urandom_range(0, 255)), t_byte'($urandom_range(0, 255)),
                             start);
    endfunction

    // restart the stripe rather than read a line buffer entry never written
    task automatic push_pixel(t_residual it);
        if (!it.stripe_start && !first_row && !row_store_valid[col_pos])
            it.stripe_start = 1'b1;
        pixel_queue.insert(pixel_queue.size(), it);
        pixel_expect_q.insert(pixel_expect_q.size(), rebuild_pixel(it));
    endtask

    task automatic write_reg(logic [IDX_W-1:0] idx, logic [DATA_W-1:0] val);
        @(posedge i_clk);
        cfg_if.valid <= 1'b1;
        cfg_if.index <= idx;
        cfg_if.data  <= val;
        @(posedge i_clk);
        while (!cfg_if.ready) @(posedge i_clk);
        cfg_if.valid <= 1'b0;
        if (idx == REG_IMAGE_WIDTH)
            cfg_width = val[WIDTH_W-1:0];
        else if (idx == REG_CHANNEL_COUNT)
            cfg_chans = val[CHAN_W-1:0];
    endtask

    task automatic wait_drained();
        while (pixel_expect_q.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    // input driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            in_if.valid        <= 1'b0;
            in_if.residual_c0  <= '0;
            in_if.residual_c1  <= '0;
            in_if.residual_c2  <= '0;
            in_if.residual_c3  <= '0;
            in_if.stripe_start <= 1'b0;
            src_gap = 0;
        end else if (!in_if.valid || in_if.ready) begin
            if (in_if.valid)
                src_gap = src_idle_on ? idle_gap() : 0;
            if (src_gap != 0) begin
                src_gap--;
                in_if.valid <= 1'b0;
            end else if (pixel_queue.size() != 0) begin
                cur_item = pixel_queue.pop_front();
                in_if.residual_c0  <= cur_item.res[0];
                in_if.residual_c1  <= cur_item.res[1];
                in_if.residual_c2  <= cur_item.res[2];
                in_if.residual_c3  <= cur_item.res[3];
                in_if.stripe_start <= cur_item.stripe_start;
                in_if.valid        <= 1'b1;
            end else begin
                in_if.valid <= 1'b0;
            end
        end
    end

    // long receiver hold-off
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            hold_seen <= hold_go;
            hold_left <= 0;
        end else if (hold_go != hold_seen) begin
            hold_seen <= hold_go;
            hold_left <= hold_len;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
        end
    end

    // output monitor
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            out_if.ready <= 1'b0;
            snk_gap = 0;
        end else begin
            if (out_if.valid && out_if.ready) begin
                got_px.pix = {out_if.pixel_c3, out_if.pixel_c2, out_if.pixel_c1,
                              out_if.pixel_c0};
                got_px.row_end = out_if.row_end;
                if (pixel_expect_q.size() == 0) begin
                    report_mismatch($sformatf("pixel %0d with none expected", result_no));
                end else begin
                    want_px = pixel_expect_q.pop_front();
                    for (int c = 0; c < NUM_LANES; c++)
                        if (got_px.pix[c] !== want_px.pix[c])
                            report_mismatch($sformatf("pixel %0d pixel_c%0d got %h want %h",
                                result_no, c, got_px.pix[c], want_px.pix[c]));
                    if (got_px.row_end !== want_px.row_end)
                        report_mismatch($sformatf("pixel %0d row_end got %b want %b",
                            result_no, got_px.row_end, want_px.row_end));
                end
                result_no++;
                snk_gap = snk_idle_on ? idle_gap() : 0;
            end
            if (hold_left != 0) begin
                out_if.ready <= 1'b0;
            end else if (snk_gap != 0) begin
                snk_gap--;
                out_if.ready <= 1'b0;
            end else begin
                out_if.ready <= 1'b1;
            end
        end
    end

    initial begin
        int                total;
        int                phase_no;
        int                n;
        int                ns;
        int                w;
        int                rows;
        int                len;
        logic              start;
        logic [DATA_W-1:0] chan_data;

        i_rst_n = 1'b0;
        cfg_if.valid = 1'b0;
        cfg_if.index = REG_IMAGE_WIDTH;
        cfg_if.data = '0;

        for (int i = 0; i < MAX_WIDTH; i++) begin
            row_store[i] = '0;
            row_store_valid[i] = 1'b0;
        end
        left_word = '0;
        col_pos = 0;
        first_row = 1'b1;
        cfg_width = WIDTH_RESET;
        cfg_chans = CHAN_RESET;

        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // reset settings, first pixel without a stripe flag
        push_pixel(make_residual(8'hFF, 8'hFF, 8'hFF, 8'hFF, 1'b0));
        push_pixel(make_residual(8'h01, 8'h01, 8'h01, 8'h01, 1'b0));
        push_pixel(make_residual(8'h80, 8'h7F, 8'h00, 8'h55, 1'b0));
        push_pixel(make_residual(8'hAA, 8'h00, 8'hFF, 8'hFF, 1'b0));
        wait_drained();

        // narrow image, all predictions including a 9-bit average sum
        write_reg(REG_IMAGE_WIDTH, 11'd3);
        write_reg(REG_CHANNEL_COUNT, 11'd4);
        push_pixel(make_residual(8'hFF, 8'h00, 8'hFF, 8'h00, 1'b1));
        push_pixel(make_residual(8'hFF, 8'hFF, 8'h00, 8'h00, 1'b0));
        push_pixel(make_residual(8'h01, 8'h02, 8'h03, 8'h04, 1'b0));
        push_pixel(make_residual(8'h00, 8'h00, 8'h00, 8'h00, 1'b0));
        push_pixel(make_residual(8'h00, 8'hFF, 8'h80, 8'h01, 1'b0));
        push_pixel(make_residual(8'hFF, 8'hFF, 8'hFF, 8'hFF, 1'b0));
        push_pixel(make_residual(8'h55, 8'hAA, 8'h55, 8'hAA, 1'b0));
        push_pixel(make_residual(8'hFF, 8'hFF, 8'hFF, 8'hFF, 1'b0));
        push_pixel(make_residual(8'h00, 8'h01, 8'h7F, 8'h80, 1'b0));
        push_pixel(make_residual(8'h10, 8'h20, 8'h30, 8'h40, 1'b0));
        push_pixel(make_residual(8'hFF, 8'hFF, 8'hFF, 8'hFF, 1'b0));
        wait_drained();

        // width shrunk while the column sits beyond it
        write_reg(REG_IMAGE_WIDTH, 11'd2);
        write_reg(REG_CHANNEL_COUNT, 11'd2);
        push_pixel(make_residual(8'h01, 8'h01, 8'h01, 8'h01, 1'b0));
        push_pixel(make_residual(8'h02, 8'h02, 8'h02, 8'h02, 1'b0));
        push_pixel(make_residual(8'h03, 8'h03, 8'h03, 8'h03, 1'b0));
        wait_drained();

        // zero width and zero channels
        write_reg(REG_IMAGE_WIDTH, 11'd0);
        write_reg(REG_CHANNEL_COUNT, 11'd0);
        push_pixel(make_residual(8'h7F, 8'hFF, 8'hFF, 8'hFF, 1'b0));
        push_pixel(make_residual(8'h81, 8'hFF, 8'hFF, 8'hFF, 1'b0));
        push_pixel(make_residual(8'hFF, 8'h00, 8'h00, 8'h00, 1'b0));
        wait_drained();

        // channel count above the maximum, width of one
        write_reg(REG_CHANNEL_COUNT, 11'd5);
        write_reg(REG_IMAGE_WIDTH, 11'd1);
        push_pixel(make_residual(8'h12, 8'h34, 8'h56, 8'h78, 1'b1));
        push_pixel(make_residual(8'hFE, 8'hDC, 8'hBA, 8'h98, 1'b0));
        wait_drained();

        // full-width image from a saturated width register
        write_reg(REG_IMAGE_WIDTH, 11'd2047);
        write_reg(REG_CHANNEL_COUNT, 11'd7);
        push_pixel(random_residual(1'b1));
        for (int k = 1; k < MAX_WIDTH + 2; k++)
            push_pixel(random_residual(1'b0));
        wait_drained();

        total = 0;
        phase_no = 0;
        while (total < 200) begin
            if (phase_no == 0) begin
                w = $urandom_range(8, 16);
            end else begin
                case ($urandom_range(0, 19))
                    0:       w = 0;
                    1:       w = $urandom_range(32, 64);
                    default: w = $urandom_range(1, 12);
                endcase
            end
            chan_data = DATA_W'($urandom_range(0, 7));
            if ($urandom_range(0, 3) == 0)
                chan_data[DATA_W-1:CHAN_W] = (DATA_W-CHAN_W)'($urandom_range(1, 255));
            if (phase_no == 0 || $urandom_range(0, 3) != 0)
                write_reg(REG_IMAGE_WIDTH, DATA_W'(w));
            if (phase_no == 0 || $urandom_range(0, 3) != 0)
                write_reg(REG_CHANNEL_COUNT, chan_data);

            src_idle_on = ($urandom_range(0, 3) != 0);
            snk_idle_on = ($urandom_range(0, 3) != 0);
            n = 0;
            ns = (phase_no == 0) ? 2 : $urandom_range(1, 3);
            for (int s = 0; s < ns; s++) begin
                rows = (phase_no == 0) ? 4 : $urandom_range(1, 4);
                len = rows * eff_width() + $urandom_range(0, eff_width() - 1);
                for (int k = 0; k < len; k++) begin
                    if (k == 0)
                        start = ($urandom_range(0, 9) != 0);
                    else
                        start = ($urandom_range(0, 49) == 0);
                    push_pixel(random_residual(start));
                    n++;
                end
            end
            // stall the output while the input keeps offering
            if (phase_no == 0 || $urandom_range(0, 6) == 0) begin
                if (phase_no == 0)
                    src_idle_on = 1'b0;
                hold_len = $urandom_range(150, 400);
                hold_go <= ~hold_go;
            end
            wait_drained();
            total += n;
            phase_no++;
        end

        wait_drained();
        if (error_count == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

    initial begin
        #30ms;
        $display("CHECK FAILED");
        $finish;
    end

endmodule
